// ===== src/srg_pkg.sv =====
// Shared types, constants and helpers of the subtractive random generator.
// No dependencies; imported by the top, the sequencer and the checker.
package srg_pkg;

  localparam int unsigned MODULUS     = 1000000000;
  localparam int unsigned GOLDEN_SEED = 161803398;
  localparam int unsigned SCATTER     = 21;
  localparam int unsigned LAG_LEN     = 55;
  localparam int unsigned LAG_OFFSET  = 30;
  localparam int unsigned TRAIL_START = 31;
  localparam int unsigned TABLE_DEPTH = 56;
  localparam int unsigned WARM_PASSES = 4;

  localparam int unsigned VALUE_W = 30;
  localparam int unsigned SEED_W  = 31;
  localparam int unsigned PTR_W   = $clog2(TABLE_DEPTH);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [PTR_W-1:0]   ptr_t;

  // table port requests from the sequencer
  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    value_t wdata;
    ptr_t   raddr_a;
    ptr_t   raddr_b;
  } srg_mem_req_t;

  // one finished draw handed to the output register
  typedef struct packed {
    logic   valid;
    value_t value;
    logic   did_seed;
  } srg_result_t;

  // a - b modulo 10^9, both operands below 10^9
  function automatic value_t sub_mod(input value_t a, input value_t b);
    logic [VALUE_W:0] sum;
    begin
      if (a >= b) begin
        sum = {1'b0, a} - {1'b0, b};
      end else begin
        sum = {1'b0, a} + (VALUE_W+1)'(MODULUS) - {1'b0, b};
      end
      sub_mod = sum[VALUE_W-1:0];
    end
  endfunction

  // pointer advance, wrapping past the last entry to 1
  function automatic ptr_t ptr_inc(input ptr_t p);
    begin
      if (p == ptr_t'(TABLE_DEPTH - 1)) begin
        ptr_inc = ptr_t'(1);
      end else begin
        ptr_inc = p + ptr_t'(1);
      end
    end
  endfunction

endpackage

// ===== src/subtractive_random_generator_unit.sv =====
// Top level of the subtractive random generator: lag table RAM, sequencer
// and output register. Uses srg_pkg, srg_ram and srg_seq.
//
// Usage:
//   Slave channel s_*: one item per requested draw. s_tuser is the op
//   (0 draw, 1 reseed then draw), s_tdata carries the seed magnitude.
//   Master channel m_*: one item per input item, m_tdata the value in
//   units of 1e-9, m_tuser set when the table was reseeded first.
//   A plain draw: the table read is issued in the cycle the item is
//   accepted; the difference is written back and registered for output
//   once the output register is free, and only then is a new item taken.
//   A reseed (or the first draw after reset) runs an init write of entry
//   55, a scatter of 54 writes and 4 warm-up passes of 55 read/write
//   pairs before the draw. s_tready is low for the whole sequence.
//   Reset returns the pointers to their start and clears the seeded
//   flag; the table is not cleared, the first item always seeds it.
//   When m_tready is low the result waits in the output register; one
//   more item is taken meanwhile and holds before its write-back.
module subtractive_random_generator_unit import srg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] seed_magnitude
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [29:0] value
  output logic        m_tuser    // [0] did_seed
);

  srg_mem_req_t mem_req;
  srg_result_t  result;
  value_t       rdata_a;
  value_t       rdata_b;
  logic         out_free;
  value_t       out_value;
  logic         out_did_seed;

  assign out_free = !m_tvalid || m_tready;

  srg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  srg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_seed  (s_tdata[SEED_W-1:0]),
    .out_free (out_free),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .mem_req  (mem_req),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_value    <= result.value;
      out_did_seed <= result.did_seed;
    end
  end

  assign m_tdata = {{(32 - VALUE_W){1'b0}}, out_value};
  assign m_tuser = out_did_seed;

endmodule

// ===== src/srg_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module srg_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/srg_seq.sv =====
// Sequencer of the generator: seeding sweep of plain writes, then warm-up
// passes and draws as read-modify-write on the lag table. Uses srg_pkg.
module srg_seq import srg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [SEED_W-1:0]   in_seed,
  input  logic                out_free,
  input  value_t              rdata_a,
  input  value_t              rdata_b,
  output srg_mem_req_t        mem_req,
  output srg_result_t         result
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_SCAT    = 3'd2;
  localparam logic [2:0] S_WARM_RD = 3'd3;
  localparam logic [2:0] S_WARM_WR = 3'd4;
  localparam logic [2:0] S_DRAW_RD = 3'd5;
  localparam logic [2:0] S_DRAW_WR = 3'd6;

  localparam int PASS_W = $clog2(WARM_PASSES);

  logic [2:0]        state;
  logic [2:0]        state_next;
  ptr_t              lead;
  ptr_t              trail;
  logic              seeded;
  logic              did_seed;
  logic [SEED_W-1:0] seed_mag;
  value_t            cur;
  value_t            prev;
  ptr_t              pos;
  ptr_t              cnt;
  logic [PASS_W-1:0] pass;

  logic              accept;
  logic              need_seed;
  logic [SEED_W-1:0] seed_gap;
  value_t            cur0;
  logic [PTR_W:0]    pos_sum;
  ptr_t              pos_next;
  ptr_t              partner;
  value_t            diff;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign need_seed = in_op || !seeded;

  // distance to the golden constant, then one reduction step
  always_comb begin
    if (seed_mag >= SEED_W'(GOLDEN_SEED)) begin
      seed_gap = seed_mag - SEED_W'(GOLDEN_SEED);
    end else begin
      seed_gap = SEED_W'(GOLDEN_SEED) - seed_mag;
    end
    if (seed_gap >= SEED_W'(MODULUS)) begin
      cur0 = VALUE_W'(seed_gap - SEED_W'(MODULUS));
    end else begin
      cur0 = VALUE_W'(seed_gap);
    end
  end

  assign pos_sum  = {1'b0, pos} + (PTR_W+1)'(SCATTER);
  assign pos_next = (pos_sum >= (PTR_W+1)'(LAG_LEN)) ?
                    PTR_W'(pos_sum - (PTR_W+1)'(LAG_LEN)) : PTR_W'(pos_sum);

  // entry 1 + (i + 30) mod 55
  assign partner = (cnt <= ptr_t'(LAG_LEN - LAG_OFFSET - 1)) ?
                   cnt + ptr_t'(LAG_OFFSET + 1) :
                   cnt - ptr_t'(LAG_LEN - LAG_OFFSET - 1);

  assign diff = sub_mod(rdata_a, rdata_b);

  always_comb begin
    state_next      = state;
    mem_req.we      = 1'b0;
    mem_req.waddr   = lead;
    mem_req.wdata   = diff;
    mem_req.raddr_a = ptr_inc(lead);
    mem_req.raddr_b = ptr_inc(trail);
    result.valid    = 1'b0;
    result.value    = diff;
    result.did_seed = did_seed;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = need_seed ? S_INIT : S_DRAW_WR;
        end
      end
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_t'(LAG_LEN);
        mem_req.wdata = cur0;
        state_next    = S_SCAT;
      end
      S_SCAT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = prev;
        if (cnt == ptr_t'(LAG_LEN - 1)) begin
          state_next = S_WARM_RD;
        end
      end
      S_WARM_RD: begin
        mem_req.raddr_a = cnt;
        mem_req.raddr_b = partner;
        state_next      = S_WARM_WR;
      end
      S_WARM_WR: begin
        mem_req.raddr_a = cnt;
        mem_req.raddr_b = partner;
        mem_req.we      = 1'b1;
        mem_req.waddr   = cnt;
        if (cnt == ptr_t'(LAG_LEN) && pass == PASS_W'(WARM_PASSES - 1)) begin
          state_next = S_DRAW_RD;
        end else begin
          state_next = S_WARM_RD;
        end
      end
      S_DRAW_RD: begin
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        // re-read the same entries while the output slot is busy
        mem_req.raddr_a = lead;
        mem_req.raddr_b = trail;
        if (out_free) begin
          mem_req.we   = 1'b1;
          result.valid = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      lead   <= '0;
      trail  <= ptr_t'(TRAIL_START);
      seeded <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && !need_seed) begin
            lead  <= ptr_inc(lead);
            trail <= ptr_inc(trail);
          end
        end
        S_WARM_WR: begin
          if (state_next == S_DRAW_RD) begin
            lead   <= '0;
            trail  <= ptr_t'(TRAIL_START);
            seeded <= 1'b1;
          end
        end
        S_DRAW_RD: begin
          lead  <= ptr_inc(lead);
          trail <= ptr_inc(trail);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          seed_mag <= in_seed;
          did_seed <= need_seed;
        end
      end
      S_INIT: begin
        cur  <= cur0;
        prev <= value_t'(1);
        pos  <= ptr_t'(SCATTER);
        cnt  <= ptr_t'(1);
      end
      S_SCAT: begin
        prev <= sub_mod(cur, prev);
        cur  <= prev;
        pos  <= pos_next;
        if (cnt == ptr_t'(LAG_LEN - 1)) begin
          cnt  <= ptr_t'(1);
          pass <= '0;
        end else begin
          cnt <= cnt + ptr_t'(1);
        end
      end
      S_WARM_WR: begin
        if (cnt == ptr_t'(LAG_LEN)) begin
          cnt  <= ptr_t'(1);
          pass <= pass + PASS_W'(1);
        end else begin
          cnt <= cnt + ptr_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/srg_checker.sv =====
// Port-level checks of the subtractive random generator, bound to the top.
// Uses srg_pkg.
module srg_checker import srg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // the block works on one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // values stay below the modulus
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata < 32'(MODULUS)))
    else $error("value out of range");

  // a reseed request is reported on its result once the output slot takes it
  a_reseed_flag: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser ##497 (!m_tvalid || m_tready)
    |=> (m_tvalid && m_tuser))
    else $error("reseed not reported");

endmodule

bind subtractive_random_generator_unit srg_checker u_srg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/tb.sv =====
// Self-checking testbench for subtractive_random_generator_unit.
// Holds its own lagged-subtraction predictor in a scoreboard class and drives random
// draw and reseed items with random gaps on both sides. Needs srg_pkg and the block.
module tb;
  import srg_pkg::*;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int IDLE_PCT     = 21;

  typedef struct {
    value_t value;
    logic   did_seed;
  } draw_t;

  class ran_draw_scoreboard;
    value_t lag_words[TABLE_DEPTH];
    ptr_t   lead;
    ptr_t   trail;
    bit     seeded;
    draw_t  pending_draws[$];
    int     mismatches;

    function new();
      lead       = '0;
      trail      = ptr_t'(TRAIL_START);
      seeded     = 1'b0;
      mismatches = 0;
    endfunction

    function value_t mod_diff(value_t a, value_t b);
      int unsigned t;
      if (a >= b) begin
        t = a - b;
      end else begin
        t = int'(a) + MODULUS - b;
      end
      return value_t'(t);
    endfunction

    function ptr_t wrap_next(ptr_t p);
      return (p == ptr_t'(TABLE_DEPTH - 1)) ? ptr_t'(1) : p + ptr_t'(1);
    endfunction

    function void fill_table(logic [SEED_W-1:0] mag);
      int unsigned seed_gap;
      value_t      cur;
      value_t      prev;
      int unsigned pos;
      int          i;
      int          k;
      seed_gap = (mag >= GOLDEN_SEED) ? mag - GOLDEN_SEED : GOLDEN_SEED - mag;
      cur  = value_t'(seed_gap % MODULUS);
      lag_words[LAG_LEN] = cur;
      prev = value_t'(1);
      for (i = 1; i < LAG_LEN; i++) begin
        pos = (SCATTER * i) % LAG_LEN;
        lag_words[pos] = prev;
        prev = mod_diff(cur, prev);
        cur  = lag_words[pos];
      end
      // warm-up: lag-31 subtraction over the whole table
      for (k = 1; k <= WARM_PASSES; k++) begin
        for (i = 1; i <= LAG_LEN; i++) begin
          lag_words[i] = mod_diff(lag_words[i], lag_words[1 + (i + LAG_OFFSET) % LAG_LEN]);
        end
      end
      lead   = '0;
      trail  = ptr_t'(TRAIL_START);
      seeded = 1'b1;
    endfunction

    // accepted input item: predict its draw
    function void note_request(logic op, logic [SEED_W-1:0] mag);
      draw_t d;
      d.did_seed = 1'b0;
      if (op == OP_RESEED || !seeded) begin
        fill_table(mag);
        d.did_seed = 1'b1;
      end
      lead  = wrap_next(lead);
      trail = wrap_next(trail);
      d.value = mod_diff(lag_words[lead], lag_words[trail]);
      lag_words[lead] = d.value;
      pending_draws = {pending_draws, d};
    endfunction

    function void check_draw(value_t got_value, logic got_did);
      draw_t d;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: value %0d did_seed %0b", got_value, got_did);
        end
        return;
      end
      d = pending_draws.pop_front();
      if (got_value !== d.value || got_did !== d.did_seed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("draw mismatch: expected value %0d did_seed %0b, got value %0d did_seed %0b",
                   d.value, d.did_seed, got_value, got_did);
        end
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [30:0] seed_magnitude
  logic        s_tuser;   // [0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [29:0] value
  logic        m_tuser;   // [0] did_seed

  ran_draw_scoreboard sb = new();
  bit steady = 1'b0;   // no idling on either side while set
  int cycles = 0;

  subtractive_random_generator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random backpressure, check every accepted result
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_draw(m_tdata[VALUE_W-1:0], m_tuser);
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_request(input logic op, input logic [SEED_W-1:0] mag);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, mag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, mag);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic              op;
    logic [SEED_W-1:0] mag;
    int                n;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: draw before any seed forces seeding, here from zero
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, 31'h7FFF_FFFF);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, 31'h7FFF_FFFF);
    send_request(OP_DRAW, 31'h5555_5555);
    send_request(OP_RESEED, SEED_W'(GOLDEN_SEED));       // distance zero
    send_request(OP_RESEED, SEED_W'(GOLDEN_SEED - 1));
    send_request(OP_RESEED, SEED_W'(GOLDEN_SEED + 1));   // seed above the constant
    send_request(OP_RESEED, SEED_W'(MODULUS + GOLDEN_SEED));      // distance wraps to 0
    send_request(OP_RESEED, SEED_W'(MODULUS + GOLDEN_SEED - 1));
    send_request(OP_RESEED, SEED_W'(MODULUS + GOLDEN_SEED + 1));
    send_request(OP_DRAW, 31'h2AAA_AAAA);
    send_request(OP_RESEED, SEED_W'(1));
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, '0);
    send_request(OP_DRAW, 31'h7FFF_FFFF);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 500 && n < 800);
      if (n == 1000) begin
        wait_drain();
      end
      op = ($urandom_range(24) == 0) ? OP_RESEED : OP_DRAW;
      case ($urandom_range(9))
        0: mag = '0;
        1: mag = 31'h7FFF_FFFF;
        2: mag = SEED_W'(GOLDEN_SEED - 2 + $urandom_range(4));
        3: mag = SEED_W'(MODULUS + GOLDEN_SEED - 2 + $urandom_range(4));
        4: mag = SEED_W'($urandom_range(255));
        default: mag = SEED_W'($urandom);
      endcase
      send_request(op, mag);
    end
    steady = 1'b0;

    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/srg_pkg.sv
src/srg_ram.sv
src/srg_seq.sv
src/subtractive_random_generator_unit.sv
src/srg_checker.sv
sim/tb.sv
